// File: sv/sfr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sequenced fragment reassembly unit.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  localparam int SEQ_W = 31;
  localparam int LEN_W = 16;

  localparam logic [LEN_W-1:0] FRAGMENT_BYTES     = 16'd1300;
  localparam logic [LEN_W:0]   EXTENDED_MAX_BYTES = 17'd32768;
  localparam logic [LEN_W:0]   STOCK_MAX_BYTES    = 17'd16384;
  localparam logic [LEN_W-1:0] HDR_BYTES          = 16'd4;
  localparam logic [LEN_W-1:0] BUF_RESET_BYTES    = 16'd16384;

  // Queue between the classifier and the execution stage.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes (byte address is four times the index).
  localparam logic REG_EXT_MODE = 1'b0;
  localparam logic REG_BUF_BYTES = 1'b1;

  typedef enum logic [2:0] {
    ST_WHOLE   = 3'd0,
    ST_STALE   = 3'd1,
    ST_GAP     = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_STORED  = 3'd4,
    ST_TOOBIG  = 3'd5,
    ST_REASM   = 3'd6
  } status_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic             frag;
    logic [SEQ_W-1:0] seq;
    logic             fstart_hi_zero;
    logic [LEN_W-1:0] fstart_lo;
    logic             flen_bad;
    logic [LEN_W-2:0] flen_mag;
    logic             flen_full;
  } item_t;

  // Configuration as the execution stage sees it.
  typedef struct packed {
    logic             ext_mode;
    logic             buf_small;
    logic [LEN_W-1:0] buf_room;
  } cfg_t;

endpackage

// File: sv/sfr_front.sv
`timescale 1ns / 1ps
// Front end: classifies an incoming header with all checks that need no state.
// Depends on sfr_pkg.
module sfr_front (
  input  logic [31:0]                   header_word,
  input  logic [31:0]                   fragment_start,
  input  logic [15:0]                   fragment_length,
  input  logic [15:0]                   payload_bytes,
  output sfr_pkg::item_t                item
);
  import sfr_pkg::*;

  always_comb begin
    item.frag           = header_word[31];
    item.seq            = header_word[SEQ_W-1:0];
    // The start offset can only match a 16-bit assembled length if its top half is zero.
    item.fstart_hi_zero = (fragment_start[31:LEN_W] == '0);
    item.fstart_lo      = fragment_start[LEN_W-1:0];
    // A negative length, or one longer than the bytes present, is illegal.
    item.flen_bad       = fragment_length[LEN_W-1] ||
                          ({1'b0, fragment_length[LEN_W-2:0]} > payload_bytes);
    item.flen_mag       = fragment_length[LEN_W-2:0];
    item.flen_full      = (fragment_length == FRAGMENT_BYTES);
  end

endmodule

// File: sv/sfr_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front end and the execution stage.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfr_pkg::item_t din,
  input  logic           pop,
  output sfr_pkg::item_t dout,
  output logic           not_empty,
  output logic           full
);
  import sfr_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign dout      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: sv/sfr_back.sv
`timescale 1ns / 1ps
// Execution stage: applies one queued item to the sequence and reassembly state
// and holds the result in the output register. Depends on sfr_pkg.
module sfr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfr_pkg::cfg_t                 cfg,
  input  sfr_pkg::item_t                item,
  input  logic                          item_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic                          out_deliver,
  output logic [sfr_pkg::SEQ_W-1:0]     out_lost_packets,
  output logic [sfr_pkg::LEN_W-1:0]     out_write_offset,
  output logic [sfr_pkg::LEN_W-1:0]     out_delivered_length,
  output logic [sfr_pkg::SEQ_W-1:0]     out_sequence_out
);
  import sfr_pkg::*;

  logic [SEQ_W-1:0] last_r, last_nxt;
  logic [SEQ_W-1:0] frag_seq_r, frag_seq_nxt;
  logic [LEN_W-1:0] asm_r, asm_nxt;
  logic             valid_r, valid_nxt;

  status_t          status_r, status_nxt;
  logic             deliver_r, deliver_nxt;
  logic [SEQ_W-1:0] lost_r, lost_nxt;
  logic [LEN_W-1:0] woff_r, woff_nxt;
  logic [LEN_W-1:0] dlen_r, dlen_nxt;
  logic [SEQ_W-1:0] seq_r;

  logic             stale;
  logic [LEN_W-1:0] asm_eff;
  logic [LEN_W:0]   sum;
  logic [LEN_W:0]   limit;

  assign pop = item_valid && (!valid_r || !out_stall);

  always_comb begin
    stale   = (item.seq <= last_r);
    // A new fragment sequence starts assembly from zero.
    asm_eff = (item.seq != frag_seq_r) ? '0 : asm_r;
    sum     = {1'b0, asm_eff} + {2'b0, item.flen_mag};
    limit   = cfg.ext_mode ? EXTENDED_MAX_BYTES : STOCK_MAX_BYTES;

    status_nxt   = ST_STALE;
    deliver_nxt  = 1'b0;
    lost_nxt     = '0;
    woff_nxt     = '0;
    dlen_nxt     = '0;
    last_nxt     = last_r;
    frag_seq_nxt = frag_seq_r;
    asm_nxt      = asm_r;

    if (!stale) begin
      lost_nxt = item.seq - last_r - 1'b1;
      if (!item.frag) begin
        last_nxt    = item.seq;
        status_nxt  = ST_WHOLE;
        deliver_nxt = 1'b1;
      end else begin
        frag_seq_nxt = item.seq;
        asm_nxt      = asm_eff;
        if (!item.fstart_hi_zero || item.fstart_lo != asm_eff) begin
          status_nxt = ST_GAP;
        end else if (item.flen_bad || sum > limit) begin
          status_nxt = ST_ILLEGAL;
        end else begin
          woff_nxt = asm_eff;
          asm_nxt  = sum[LEN_W-1:0];
          if (item.flen_full) begin
            status_nxt = ST_STORED;
          end else if (cfg.buf_small || sum[LEN_W-1:0] > cfg.buf_room) begin
            // Too large: the bytes stay counted as assembled.
            status_nxt = ST_TOOBIG;
          end else begin
            status_nxt  = ST_REASM;
            deliver_nxt = 1'b1;
            dlen_nxt    = sum[LEN_W-1:0] + HDR_BYTES;
            asm_nxt     = '0;
          end
        end
      end
    end

    valid_nxt = pop ? 1'b1 : (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      last_r     <= '0;
      frag_seq_r <= '0;
      asm_r      <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (pop) begin
        last_r     <= last_nxt;
        frag_seq_r <= frag_seq_nxt;
        asm_r      <= asm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r  <= status_nxt;
      deliver_r <= deliver_nxt;
      lost_r    <= lost_nxt;
      woff_r    <= woff_nxt;
      dlen_r    <= dlen_nxt;
      seq_r     <= item.seq;
    end
  end

  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_deliver          = deliver_r;
  assign out_lost_packets     = lost_r;
  assign out_write_offset     = woff_r;
  assign out_delivered_length = dlen_r;
  assign out_sequence_out     = seq_r;

endmodule

// File: sv/sequenced_fragment_reassembly_unit.sv
// Sequenced fragment reassembly unit: one packet header per item, one result per item.
// The header is classified into the queue at its accepting edge and executed into the output
// register when the execution stage pops it. Throughput is one item per cycle while out_stall
// is low, set by the registered state update of the execution stage. Reset (synchronous, active
// low) clears the sequence and reassembly state, empties the queue and output register, and
// restores extended_mode to 0 and deliver_buffer_bytes to 16384.
`timescale 1ns / 1ps
module sequenced_fragment_reassembly_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_header_word,
  input  logic [31:0]               in_fragment_start,
  input  logic [15:0]               in_fragment_length,
  input  logic [15:0]               in_payload_bytes,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_status,
  output logic                      out_deliver,
  output logic [sfr_pkg::SEQ_W-1:0] out_lost_packets,
  output logic [sfr_pkg::LEN_W-1:0] out_write_offset,
  output logic [sfr_pkg::LEN_W-1:0] out_delivered_length,
  output logic [sfr_pkg::SEQ_W-1:0] out_sequence_out,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sfr_pkg::*;

  // Configuration registers. The buffer room (capacity less the four header bytes) and
  // the flag for a buffer too small to hold even the header are worked out when the
  // register is written, so the execution stage only has to compare against them.
  logic             ext_mode_r, ext_mode_nxt;
  logic [LEN_W-1:0] buf_bytes_r, buf_bytes_nxt;
  logic             buf_small_r, buf_small_nxt;
  logic [LEN_W-1:0] buf_room_r, buf_room_nxt;
  logic             cfg_write;
  logic             cfg_index;
  cfg_t             cfg;

  // Front end to queue, queue to execution stage.
  item_t            front_item;
  item_t            q_item;
  logic             q_not_empty;
  logic             q_full;
  logic             q_push;
  logic             q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // Registers sit on word boundaries; bit 2 of the address picks the register.
  assign cfg_index = paddr[2];

  always_comb begin
    ext_mode_nxt  = ext_mode_r;
    buf_bytes_nxt = buf_bytes_r;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_EXT_MODE:  ext_mode_nxt  = pwdata[0];
        REG_BUF_BYTES: buf_bytes_nxt = pwdata[LEN_W-1:0];
        default:       ext_mode_nxt  = ext_mode_r;
      endcase
    end
    buf_small_nxt = (buf_bytes_nxt < HDR_BYTES);
    buf_room_nxt  = buf_bytes_nxt - HDR_BYTES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_mode_r  <= 1'b0;
      buf_bytes_r <= BUF_RESET_BYTES;
      buf_small_r <= 1'b0;
      buf_room_r  <= BUF_RESET_BYTES - HDR_BYTES;
    end else begin
      ext_mode_r  <= ext_mode_nxt;
      buf_bytes_r <= buf_bytes_nxt;
      buf_small_r <= buf_small_nxt;
      buf_room_r  <= buf_room_nxt;
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_EXT_MODE:  prdata = {31'b0, ext_mode_r};
      REG_BUF_BYTES: prdata = {16'b0, buf_bytes_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.ext_mode  = ext_mode_r;
  assign cfg.buf_small = buf_small_r;
  assign cfg.buf_room  = buf_room_r;

  // The queue decouples the two halves: the input is stalled only when it is full,
  // so a result waiting at the output does not hold up acceptance of the next item.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  sfr_front u_front (
    .header_word     (in_header_word),
    .fragment_start  (in_fragment_start),
    .fragment_length (in_fragment_length),
    .payload_bytes   (in_payload_bytes),
    .item            (front_item)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (front_item),
    .pop       (q_pop),
    .dout      (q_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  sfr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .item                 (q_item),
    .item_valid           (q_not_empty),
    .pop                  (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_deliver          (out_deliver),
    .out_lost_packets     (out_lost_packets),
    .out_write_offset     (out_write_offset),
    .out_delivered_length (out_delivered_length),
    .out_sequence_out     (out_sequence_out)
  );

`ifndef SYNTH
  // A message is handed upward only for a whole packet or a completed reassembly.
  a_deliver_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver |-> (out_status == ST_WHOLE || out_status == ST_REASM))
    else $error("deliver flag set for a non-delivering status");

  // Only a reassembled delivery reports a length, and it always includes the header.
  a_dlen_only_reasm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_REASM |-> out_delivered_length == '0)
    else $error("delivered length reported outside a reassembled delivery");

  // A stale packet changes nothing and reports no gap and no offset.
  a_stale_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_STALE |-> out_lost_packets == '0 && out_write_offset == '0)
    else $error("stale packet carries a gap or an offset");

  // The output register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
